// ----- sv/obpe_pkg.sv -----
package obpe_pkg;

  localparam logic [23:0] RawLow  = 24'd419430;
  localparam logic [21:0] RawSpan = 22'd3355444;
  localparam logic [12:0] PFull   = 13'd4800;
  localparam logic [9:0]  HrMax   = 10'd1023;

  // p = floor(d * 4800 / 3355444) = floor(d * 1200 / 838861)
  localparam logic [10:0] ScaleMul   = 11'd1200;
  localparam logic [19:0] ScaleDiv   = 20'd838861;
  localparam logic [13:0] ScaleRecip = 14'd10239;  // floor(2^33 / 838861)

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_INFL = 2'd1,
    PH_DEFL = 2'd2,
    PH_DONE = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ADV_NONE = 2'd0,
    ADV_OK   = 2'd1,
    ADV_FAST = 2'd2,
    ADV_SLOW = 2'd3
  } advice_e;

  typedef enum logic [1:0] {
    ERR_OK    = 2'd0,
    ERR_NOPUL = 2'd1,
    ERR_SPAN  = 2'd2,
    ERR_OVF   = 2'd3
  } error_e;

  typedef enum logic [2:0] {
    CS_IDLE  = 3'd0,
    CS_SDIV  = 3'd1,
    CS_EVAL  = 3'd2,
    CS_HDIV  = 3'd3,
    CS_OUT   = 3'd4
  } ctrl_e;

  localparam logic [2:0] RegInflate = 3'd0;
  localparam logic [2:0] RegStop    = 3'd1;
  localparam logic [2:0] RegFloor   = 3'd2;
  localparam logic [2:0] RegCeil    = 3'd3;
  localparam logic [2:0] RegFast    = 3'd4;
  localparam logic [2:0] RegSlow    = 3'd5;
  localparam logic [2:0] RegBeats   = 3'd6;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture request, start pressure scaling
    logic scale_step;  // one scaling stage
    logic div_step;    // one divider iteration
    logic eval;        // apply sample to measurement state
    logic hr_start;    // load heart rate division
    logic out_load;    // latch result register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scale_done;
    logic div_done;
    logic need_hr;
  } status_t;

endpackage

// ----- sv/obpe_ctrl.sv -----
module obpe_ctrl
  import obpe_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_fire_i,
  input  logic    out_free_i,
  input  status_t stat_i,
  output cmd_t    cmd_o,
  output logic    busy_o
);

  ctrl_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= CS_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      CS_IDLE: if (in_fire_i) state_d = CS_SDIV;
      CS_SDIV: if (stat_i.scale_done) state_d = CS_EVAL;
      CS_EVAL: state_d = stat_i.need_hr ? CS_HDIV : CS_OUT;
      CS_HDIV: if (stat_i.div_done) state_d = CS_OUT;
      CS_OUT:  if (out_free_i) state_d = CS_IDLE;
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    busy_o = 1'b1;
    case (state_q)
      CS_IDLE: begin
        busy_o = 1'b0;
        cmd_o.load = in_fire_i;
      end
      CS_SDIV: cmd_o.scale_step = !stat_i.scale_done;
      CS_EVAL: begin
        cmd_o.eval = 1'b1;
        cmd_o.hr_start = stat_i.need_hr;
      end
      CS_HDIV: cmd_o.div_step = !stat_i.div_done;
      CS_OUT:  cmd_o.out_load = out_free_i;
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_eval_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.eval |-> $past(state_q) == CS_SDIV) else $error("eval without division");
  a_no_load_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> state_q == CS_IDLE) else $error("load while busy");
  a_out_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> state_q == CS_IDLE) else $error("output not closed");
`endif

endmodule

// ----- sv/obpe_dp.sv -----
module obpe_dp
  import obpe_pkg::*;
#(
  parameter int MaxSamples = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     stat_o,
  input  logic        op_i,
  input  logic [23:0] raw_i,
  input  logic [12:0] inflate_target_i,
  input  logic [12:0] stop_level_i,
  input  logic [12:0] search_floor_i,
  input  logic [12:0] window_ceiling_i,
  input  logic [12:0] fast_limit_i,
  input  logic [12:0] slow_limit_i,
  input  logic [15:0] beats_scale_i,
  output logic [12:0] pressure_o,
  output logic [1:0]  phase_o,
  output logic [1:0]  rate_advice_o,
  output logic        measurement_done_o,
  output logic [1:0]  result_error_o,
  output logic [12:0] systolic_o,
  output logic [12:0] mean_pressure_o,
  output logic [12:0] diastolic_o,
  output logic [9:0]  heart_rate_o
);

  localparam int IW = $clog2(MaxSamples + 1);
  localparam int NW = 16 + IW;
  localparam int DW = IW;
  localparam int CW = $clog2(NW + 1);
  localparam logic [IW-1:0] MaxIdx = IW'(MaxSamples);

  // heart rate restoring divider
  logic [NW-1:0] num_q;
  logic [DW:0]   rem_q;
  logic [DW-1:0] den_q;
  logic [CW-1:0] cnt_q;
  logic          op_q;
  logic [12:0]   p_q;

  // pressure scaling stages
  logic [31:0] sx_q;
  logic [12:0] sq_q;
  logic [1:0]  sc_cnt_q;

  phase_e      phase_q;
  logic [12:0] last_q, firstp_q, peakd_q, peakp_q;
  logic [IW-1:0] idx_q, firsti_q, peaki_q, pos_q, cpk_q;
  logic        ffound_q, closed_q;

  // result staging
  logic [12:0] r_p_q, r_sys_q, r_mean_q, r_dia_q;
  logic [1:0]  r_adv_q, r_err_q;
  logic        r_done_q, r_hr_q;

  logic [DW:0]   trial;
  logic          fits;
  logic [NW-1:0] num_d;
  logic [DW:0]   rem_d;
  always_comb begin
    trial = {rem_q[DW-1:0], num_q[NW-1]};
    fits  = trial >= {1'b0, den_q};
    rem_d = fits ? trial - {1'b0, den_q} : trial;
    num_d = {num_q[NW-2:0], fits};
  end

  assign stat_o.div_done = (cnt_q == '0);

  // offset clamped to the full span, reciprocal estimate then one correction
  logic [23:0] d_raw;
  logic [21:0] d_clamp;
  always_comb begin
    d_raw = raw_i - RawLow;
    if (raw_i <= RawLow) d_clamp = '0;
    else if (d_raw >= 24'(RawSpan)) d_clamp = RawSpan;
    else d_clamp = d_raw[21:0];
  end

  logic [45:0] s_prod;
  logic [31:0] s_rem;
  assign s_prod = 46'(sx_q) * 46'(ScaleRecip);
  assign s_rem  = sx_q - 32'(sq_q) * 32'(ScaleDiv);
  assign stat_o.scale_done = (sc_cnt_q == 2'd0);

  logic [12:0] p_now;
  assign p_now = op_q ? p_q : 13'd0;

  logic signed [13:0] diff;
  logic [12:0] mag;
  logic pos, in_win;
  assign diff   = $signed({1'b0, p_now}) - $signed({1'b0, last_q});
  assign mag    = diff[13] ? 13'(-diff) : diff[12:0];
  assign pos    = !diff[13] && (diff != '0);
  assign in_win = p_now < window_ceiling_i;

  // what the eval step decides
  logic fin, ovf, nopul, span0, defl_diff;
  logic [IW-1:0] span;
  logic [IW-1:0] cnt_eff;
  always_comb begin
    fin = 1'b0; ovf = 1'b0; defl_diff = 1'b0;
    if (op_q && phase_q == PH_DEFL) begin
      if (p_now < stop_level_i) fin = 1'b1;
      else if (idx_q == '0) fin = 1'b0;
      else if (idx_q >= MaxIdx) begin fin = 1'b1; ovf = 1'b1; end
      else defl_diff = 1'b1;
    end
    nopul = !ffound_q || (peakd_q == '0);
    span  = peaki_q - firsti_q;
    span0 = (span == '0);
    cnt_eff = cpk_q;
  end
  assign stat_o.need_hr = fin && !ovf && !nopul && !span0 && (beats_scale_i != '0);

  logic [14:0] tri3;
  logic signed [15:0] dia_w;
  logic [12:0] dia_s;
  always_comb begin
    tri3  = 15'(peakp_q) * 15'd3;
    dia_w = $signed({1'b0, tri3}) - $signed({3'b0, firstp_q});
    dia_w = dia_w >>> 1;
    if (dia_w < 0) dia_s = '0;
    else if (dia_w > $signed({3'b0, PFull})) dia_s = PFull;
    else dia_s = dia_w[12:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q <= op_i;
      sx_q <= 32'(d_clamp) * 32'(ScaleMul);
      sc_cnt_q <= 2'd2;
    end else if (cmd_i.scale_step) begin
      sc_cnt_q <= sc_cnt_q - 1'b1;
      if (sc_cnt_q == 2'd2) sq_q <= s_prod[45:33];
      else p_q <= (s_rem >= 32'(ScaleDiv)) ? sq_q + 1'b1 : sq_q;
    end
    if (cmd_i.hr_start) begin
      rem_q <= '0;
      cnt_q <= CW'(NW);
      den_q <= DW'(span);
      num_q <= NW'(beats_scale_i) * NW'(cnt_eff);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_d;
      num_q <= num_d;
      cnt_q <= cnt_q - 1'b1;
    end
    if (cmd_i.eval) begin
      r_p_q <= p_now;
      r_adv_q <= ADV_NONE;
      r_done_q <= fin;
      r_err_q <= ERR_OK;
      r_sys_q <= '0; r_mean_q <= '0; r_dia_q <= '0;
      r_hr_q <= 1'b0;
      if (defl_diff) begin
        if (mag > fast_limit_i) r_adv_q <= ADV_FAST;
        else if (mag < slow_limit_i) r_adv_q <= ADV_SLOW;
        else r_adv_q <= ADV_OK;
      end
      if (fin) begin
        if (ovf) r_err_q <= ERR_OVF;
        else if (nopul) r_err_q <= ERR_NOPUL;
        else begin
          r_err_q <= span0 ? ERR_SPAN : ERR_OK;
          r_sys_q <= firstp_q; r_mean_q <= peakp_q; r_dia_q <= dia_s;
          r_hr_q <= stat_o.need_hr;
        end
      end
    end
    if (cmd_i.out_load) begin
      pressure_o <= r_p_q;
      rate_advice_o <= r_adv_q;
      measurement_done_o <= r_done_q;
      result_error_o <= r_err_q;
      systolic_o <= r_sys_q;
      mean_pressure_o <= r_mean_q;
      diastolic_o <= r_dia_q;
      phase_o <= phase_q;
      if (!r_hr_q) heart_rate_o <= '0;
      else if (num_q > NW'(HrMax)) heart_rate_o <= HrMax;
      else heart_rate_o <= num_q[9:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      last_q <= '0; firstp_q <= '0; peakd_q <= '0; peakp_q <= '0;
      idx_q <= '0; firsti_q <= '0; peaki_q <= '0; pos_q <= '0; cpk_q <= '0;
      ffound_q <= 1'b0; closed_q <= 1'b0;
    end else if (cmd_i.eval) begin
      if (!op_q) begin
        phase_q <= PH_INFL;
        last_q <= '0; firstp_q <= '0; peakd_q <= '0; peakp_q <= '0;
        idx_q <= '0; firsti_q <= '0; peaki_q <= '0; pos_q <= '0; cpk_q <= '0;
        ffound_q <= 1'b0; closed_q <= 1'b0;
      end else if (phase_q == PH_INFL) begin
        if (p_now > inflate_target_i) phase_q <= PH_DEFL;
      end else if (phase_q == PH_DEFL) begin
        if (fin) phase_q <= PH_DONE;
        else if (idx_q == '0) begin
          last_q <= p_now;
          idx_q <= IW'(1);
        end else begin
          logic ff;
          logic [IW-1:0] pc;
          ff = ffound_q;
          pc = pos_q;
          if (!ffound_q && pos && in_win) begin
            ff = 1'b1; firsti_q <= idx_q; firstp_q <= p_now; pc = '0;
          end
          if (ff && pos) pc = pc + 1'b1;
          ffound_q <= ff;
          pos_q <= pc;
          if (!closed_q) begin
            if (p_now < search_floor_i) closed_q <= 1'b1;
            else if (pos && diff[12:0] > peakd_q && in_win) begin
              peaki_q <= idx_q; peakd_q <= diff[12:0]; peakp_q <= p_now; cpk_q <= pc;
            end
          end
          last_q <= p_now;
          idx_q <= idx_q + 1'b1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= MaxIdx) else $error("sample index overrun");
  a_span_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ffound_q && peakd_q != '0) |-> peaki_q >= firsti_q) else $error("peak before systolic");
  a_done_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.eval && fin) |=> phase_q == PH_DONE) else $error("finish without done");
`endif

endmodule

// ----- sv/oscillometric_bp_estimator_top.sv -----
// per request: pressure scaling (reciprocal estimate, then one correction), eval and
// output load, with the 27-step heart rate division between eval and output load when
// the ending request yields a heart rate (plus output wait); one request at a time
// input stall is high from acceptance until the result register is loaded
// rst_ni is asynchronous active low: phase idle, measurement state zero,
// registers at their reset values, no result pending
module oscillometric_bp_estimator_top
  import obpe_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic [23:0] raw_count_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] pressure_o,
  output logic [1:0]  phase_o,
  output logic [1:0]  rate_advice_o,
  output logic        measurement_done_o,
  output logic [1:0]  result_error_o,
  output logic [12:0] systolic_o,
  output logic [12:0] mean_pressure_o,
  output logic [12:0] diastolic_o,
  output logic [9:0]  heart_rate_o,
  // configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [12:0] infl_q, stop_q, floor_q, ceil_q, fast_q, slow_q;
  logic [15:0] beats_q;
  logic [2:0]  reg_idx;
  logic        wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite;

  // register writes, out of range addresses ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      infl_q <= 13'd2400; stop_q <= 13'd480; floor_q <= 13'd800;
      ceil_q <= 13'd2400; fast_q <= 13'd16; slow_q <= 13'd4; beats_q <= 16'd240;
    end else if (wr_en) begin
      case (reg_idx)
        RegInflate: infl_q  <= pwdata[12:0];
        RegStop:    stop_q  <= pwdata[12:0];
        RegFloor:   floor_q <= pwdata[12:0];
        RegCeil:    ceil_q  <= pwdata[12:0];
        RegFast:    fast_q  <= pwdata[12:0];
        RegSlow:    slow_q  <= pwdata[12:0];
        RegBeats:   beats_q <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    prdata = '0;
    case (reg_idx)
      RegInflate: prdata = 32'(infl_q);
      RegStop:    prdata = 32'(stop_q);
      RegFloor:   prdata = 32'(floor_q);
      RegCeil:    prdata = 32'(ceil_q);
      RegFast:    prdata = 32'(fast_q);
      RegSlow:    prdata = 32'(slow_q);
      RegBeats:   prdata = 32'(beats_q);
      default:    prdata = '0;
    endcase
  end

  // output register occupancy
  logic out_valid_q, out_free, busy, in_fire;
  cmd_t cmd;
  status_t stat;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign in_stall_o = busy;
  assign in_fire    = in_valid_i && !busy;
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  obpe_ctrl u_ctrl (
    .clk_i,
    .rst_ni,
    .in_fire_i  (in_fire),
    .out_free_i (out_free),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy_o     (busy)
  );

  obpe_dp #(.MaxSamples(MAX_SAMPLES)) u_dp (
    .clk_i,
    .rst_ni,
    .cmd_i              (cmd),
    .stat_o             (stat),
    .op_i               (operation_i),
    .raw_i              (raw_count_i),
    .inflate_target_i   (infl_q),
    .stop_level_i       (stop_q),
    .search_floor_i     (floor_q),
    .window_ceiling_i   (ceil_q),
    .fast_limit_i       (fast_q),
    .slow_limit_i       (slow_q),
    .beats_scale_i      (beats_q),
    .pressure_o,
    .phase_o,
    .rate_advice_o,
    .measurement_done_o,
    .result_error_o,
    .systolic_o,
    .mean_pressure_o,
    .diastolic_o,
    .heart_rate_o
  );

`ifndef SYNTHESIS
  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> in_stall_o) else $error("accepted while busy");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o) else $error("result dropped");
  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> out_free) else $error("result overwritten");
`endif

endmodule

// ----- tb/obpe_checker.sv -----
module obpe_checker
  import obpe_pkg::*;
#(
  parameter int MAX_SAMPLES = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic        operation_i,
  input  logic [23:0] raw_count_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic [12:0] pressure_i,
  input  logic [1:0]  phase_i,
  input  logic [1:0]  rate_advice_i,
  input  logic        measurement_done_i,
  input  logic [1:0]  result_error_i,
  input  logic [12:0] systolic_i,
  input  logic [12:0] mean_pressure_i,
  input  logic [12:0] diastolic_i,
  input  logic [9:0]  heart_rate_i,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count_o,
  output int          pending_o,
  output int          done_count_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [12:0] pressure;
    logic [1:0]  phase;
    logic [1:0]  advice;
    logic        done;
    logic [1:0]  err;
    logic [12:0] sys;
    logic [12:0] mean;
    logic [12:0] dia;
    logic [9:0]  hr;
  } bp_result_t;

  bp_result_t  bp_expected_q[$];
  logic [12:0] cfg_infl, cfg_stop, cfg_floor, cfg_ceil, cfg_fast, cfg_slow;
  logic [15:0] cfg_beats;
  phase_e      st_phase;
  int          st_last, st_idx, st_fidx, st_fp, st_pidx, st_pdiff, st_pp, st_pos, st_cpk;
  bit          st_ffound, st_closed;

  assign pending_o = bp_expected_q.size();

  function automatic int scale_raw(logic [23:0] raw);
    longint q;
    if (raw <= RawLow) return 0;
    q = (longint'(raw) - 419430) * 4800 / 3355444;
    return (q > 4800) ? 4800 : int'(q);
  endfunction

  function automatic void clear_meas();
    st_last = 0; st_idx = 0; st_fidx = 0; st_ffound = 0; st_fp = 0;
    st_pidx = 0; st_pdiff = 0; st_pp = 0; st_closed = 0; st_pos = 0; st_cpk = 0;
  endfunction

  function automatic void close_meas(inout bp_result_t r, input error_e e0);
    error_e e;
    int     span;
    longint dia, hr;
    e = e0;
    st_phase = PH_DONE;
    r.done = 1'b1;
    if (e == ERR_OK && (!st_ffound || st_pdiff == 0)) e = ERR_NOPUL;
    r.err = e;
    if (e != ERR_OK) return;
    span = st_pidx - st_fidx;
    if (span == 0) r.err = ERR_SPAN;
    r.sys = st_fp;
    r.mean = st_pp;
    dia = (3 * longint'(st_pp) - st_fp) / 2;
    if (dia < 0) dia = 0;
    if (dia > 4800) dia = 4800;
    r.dia = dia;
    if (span != 0) begin
      hr = longint'(cfg_beats) * st_cpk / span;
      r.hr = (hr > 1023) ? 1023 : hr;
    end
  endfunction

  function automatic bp_result_t predict_bp(logic op, logic [23:0] raw);
    bp_result_t r;
    int p, diff, mag;
    r = '0;
    if (op == 1'b0) begin
      clear_meas();
      st_phase = PH_INFL;
      r.phase = st_phase;
      return r;
    end
    p = scale_raw(raw);
    r.pressure = p;
    if (st_phase == PH_INFL) begin
      if (p > cfg_infl) st_phase = PH_DEFL;
    end else if (st_phase == PH_DEFL) begin
      if (p < cfg_stop) close_meas(r, ERR_OK);
      else if (st_idx == 0) begin
        st_last = p;
        st_idx = 1;
      end else if (st_idx >= MAX_SAMPLES) close_meas(r, ERR_OVF);
      else begin
        diff = p - st_last;
        mag = (diff < 0) ? -diff : diff;
        if (mag > cfg_fast) r.advice = ADV_FAST;
        else if (mag < cfg_slow) r.advice = ADV_SLOW;
        else r.advice = ADV_OK;
        if (!st_ffound && diff > 0 && p < cfg_ceil) begin
          st_ffound = 1; st_fidx = st_idx; st_fp = p; st_pos = 0;
        end
        if (st_ffound && diff > 0) st_pos++;
        if (!st_closed) begin
          if (p < cfg_floor) st_closed = 1;
          else if (diff > 0 && diff > st_pdiff && p < cfg_ceil) begin
            st_pidx = st_idx; st_pdiff = diff; st_pp = p; st_cpk = st_pos;
          end
        end
        st_last = p;
        st_idx++;
      end
    end
    r.phase = st_phase;
    return r;
  endfunction

  task automatic cmp_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d actual %0d", name, exp_v, act_v);
      fail_count_o++;
    end
  endtask

  always_ff @(posedge clk_i or negedge rst_ni) begin
    bp_result_t e;
    if (!rst_ni) begin
      cfg_infl <= 13'd2400; cfg_stop <= 13'd480; cfg_floor <= 13'd800;
      cfg_ceil <= 13'd2400; cfg_fast <= 13'd16; cfg_slow <= 13'd4; cfg_beats <= 16'd240;
      st_phase = PH_IDLE;
      clear_meas();
      bp_expected_q.delete();
      fail_count_o = 0;
      done_count_o = 0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[4:2])
          RegInflate: cfg_infl  <= pwdata[12:0];
          RegStop:    cfg_stop  <= pwdata[12:0];
          RegFloor:   cfg_floor <= pwdata[12:0];
          RegCeil:    cfg_ceil  <= pwdata[12:0];
          RegFast:    cfg_fast  <= pwdata[12:0];
          RegSlow:    cfg_slow  <= pwdata[12:0];
          RegBeats:   cfg_beats <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) bp_expected_q.push_back(predict_bp(operation_i, raw_count_i));
      if (out_valid_i && !out_stall_i) begin
        if (bp_expected_q.size() == 0) begin
          $error("result with no request pending");
          fail_count_o++;
        end else begin
          e = bp_expected_q.pop_front();
          cmp_field("pressure", e.pressure, pressure_i);
          cmp_field("phase", e.phase, phase_i);
          cmp_field("rate_advice", e.advice, rate_advice_i);
          cmp_field("measurement_done", e.done, measurement_done_i);
          cmp_field("result_error", e.err, result_error_i);
          cmp_field("systolic", e.sys, systolic_i);
          cmp_field("mean_pressure", e.mean, mean_pressure_i);
          cmp_field("diastolic", e.dia, diastolic_i);
          cmp_field("heart_rate", e.hr, heart_rate_i);
          if (measurement_done_i) done_count_o++;
        end
      end
    end
  end
endmodule

// ----- tb/tb_oscillometric_bp_estimator_top.sv -----
module tb_oscillometric_bp_estimator_top;
  import obpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CycleLimit = 900000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        operation_i = 1'b0;
  logic [23:0] raw_count_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [12:0] pressure_o, systolic_o, mean_pressure_o, diastolic_o;
  logic [1:0]  phase_o, rate_advice_o, result_error_o;
  logic        measurement_done_o;
  logic [9:0]  heart_rate_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  int  fail_count, pending, done_count;
  int  cycle_count = 0;
  int  request_count = 0;
  // stall control: idle_enable gates random gaps on both sides, hold_long asks the receiver for a long hold-off
  bit  idle_enable = 1'b1;
  bit  hold_long = 1'b0;

  always #10 clk_i = ~clk_i;

  oscillometric_bp_estimator_top u_top (.*);

  obpe_checker u_chk (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_i(in_stall_o), .operation_i, .raw_count_i,
    .out_valid_i(out_valid_o), .out_stall_i, .pressure_i(pressure_o), .phase_i(phase_o),
    .rate_advice_i(rate_advice_o), .measurement_done_i(measurement_done_o),
    .result_error_i(result_error_o), .systolic_i(systolic_o),
    .mean_pressure_i(mean_pressure_o), .diastolic_i(diastolic_o),
    .heart_rate_i(heart_rate_o), .psel, .penable, .pwrite, .paddr, .pwdata,
    .fail_count_o(fail_count), .pending_o(pending), .done_count_o(done_count)
  );

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(negedge clk_i);
      if (hold_long) begin
        out_stall_i <= 1'b1;
        for (n = 0; n < 400; n++) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_long = 1'b0;
      end else if (idle_enable && $urandom_range(0, 7) == 0) begin
        out_stall_i <= 1'b1;
        n = $urandom_range(1, 18);
        repeat (n - 1) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  // register write: setup then access phase
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // offer one request, hold it until accepted
  task automatic send_req(logic op, logic [23:0] raw);
    int gap;
    if (idle_enable && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    operation_i <= op;
    raw_count_i <= raw;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    request_count++;
    @(negedge clk_i);
  endtask

  task automatic drain_all();
    in_valid_i <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (80) @(negedge clk_i);
  endtask

  // raw count for a target pressure in 1/16 mmHg, with some jitter
  function automatic logic [23:0] raw_for(int p);
    return 24'(419430 + (longint'(p) * 3355444) / 4800 + $urandom_range(0, 600));
  endfunction

  // one short measurement: start, inflate, deflate with pulses, end
  task automatic run_measurement(int top, int step, int amp);
    int p, k;
    send_req(1'b0, 24'($urandom));
    p = 0;
    while (p <= top + 40) begin
      p += $urandom_range(400, 900);
      send_req(1'b1, raw_for(p));
    end
    p = top + 40;
    k = 0;
    while (p > 300 && k < 10) begin
      p -= step + $urandom_range(0, step);
      if ($urandom_range(0, 2) == 0) p += $urandom_range(0, amp);
      if (p < 0) p = 0;
      send_req(1'b1, raw_for(p));
      k++;
    end
    send_req(1'b1, raw_for(100));
  endtask

  task automatic set_defaults();
    write_reg(RegInflate, 32'd2400); write_reg(RegStop, 32'd480);
    write_reg(RegFloor, 32'd800);    write_reg(RegCeil, 32'd2400);
    write_reg(RegFast, 32'd16);      write_reg(RegSlow, 32'd4);
    write_reg(RegBeats, 32'd240);
  endtask

  initial begin
    int i, k, op_sel;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: scaling extremes, ignored samples, restart mid deflation
    send_req(1'b1, 24'd0);
    send_req(1'b1, 24'hFFFFFF);
    send_req(1'b1, 24'd419430);
    send_req(1'b1, 24'd419431);
    send_req(1'b1, 24'd3774874);
    send_req(1'b0, 24'hFFFFFF);
    send_req(1'b1, raw_for(1000));
    send_req(1'b1, 24'hFFFFFF);            // leave inflation
    send_req(1'b1, 24'hFFFFFF);            // first deflation sample, reference only
    send_req(1'b1, 24'hFFFFFF);            // zero diff, too slow
    send_req(1'b0, 24'd0);                 // restart mid deflation
    send_req(1'b1, 24'hFFFFFF);
    send_req(1'b1, raw_for(2000));
    send_req(1'b1, raw_for(1000));         // too fast
    send_req(1'b1, raw_for(1100));         // systolic and peak on one sample
    send_req(1'b1, 24'd0);                 // end, zero span
    send_req(1'b1, 24'd5);                 // ignored while done
    drain_all();

    // a few full measurements under default settings
    run_measurement(2400, 120, 300);
    run_measurement(2600, 100, 250);
    drain_all();

    // extremes: thresholds at zero (window ceiling at full scale), then at full scale (window ceiling at zero)
    write_reg(RegInflate, 32'd0); write_reg(RegStop, 32'd0);
    write_reg(RegFloor, 32'd0);   write_reg(RegCeil, 32'd4800);
    write_reg(RegFast, 32'd0);    write_reg(RegSlow, 32'd0);
    write_reg(RegBeats, 32'hFFFF);
    run_measurement(3000, 150, 300);
    drain_all();
    write_reg(RegInflate, 32'd4800); write_reg(RegStop, 32'd4800);
    write_reg(RegFloor, 32'd4800);   write_reg(RegCeil, 32'd0);
    write_reg(RegFast, 32'd4800);    write_reg(RegSlow, 32'd4800);
    write_reg(RegBeats, 32'd1);
    send_req(1'b0, 24'd0);
    send_req(1'b1, 24'hFFFFFF);
    send_req(1'b1, 24'hFFFFFF);
    drain_all();

    // sample overflow: stop level zero, long randomly varying deflation
    write_reg(RegInflate, 32'd100); write_reg(RegStop, 32'd0);
    write_reg(RegCeil, 32'd4800);   write_reg(RegFloor, 32'd0);
    write_reg(RegFast, 32'd16);     write_reg(RegSlow, 32'd4);
    send_req(1'b0, 24'd0);
    send_req(1'b1, 24'hFFFFFF);
    for (k = 0; k < 1026; k++) send_req(1'b1, 24'($urandom_range(2000000, 3800000)));
    drain_all();
    set_defaults();

    // long receiver hold-off while requests keep coming
    hold_long = 1'b1;
    run_measurement(2500, 110, 260);
    // sender pauses until all results are back
    drain_all();

    // random phase: mostly well-formed measurements, some noise
    for (i = 0; i < 2; i++) begin
      write_reg(RegInflate, 32'($urandom_range(1500, 3500)));
      write_reg(RegStop,    32'($urandom_range(200, 900)));
      write_reg(RegFloor,   32'($urandom_range(500, 1500)));
      write_reg(RegCeil,    32'($urandom_range(1500, 4800)));
      write_reg(RegFast,    32'($urandom_range(5, 60)));
      write_reg(RegSlow,    32'($urandom_range(0, 10)));
      write_reg(RegBeats,   32'($urandom_range(0, 65535)));
      if (i == 1) idle_enable = 1'b0;
      for (k = 0; k < 2; k++) begin
        op_sel = $urandom_range(0, 4);
        if (op_sel == 0) begin
          repeat (5) send_req(1'($urandom), 24'($urandom));
        end else begin
          run_measurement($urandom_range(2000, 3800), $urandom_range(60, 150),
                          $urandom_range(0, 300));
        end
      end
      drain_all();
    end

    $display("covered %0d requests, %0d completed measurements, with register sweeps",
             request_count, done_count);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
